// File: src/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// shared types and constants for the 24cxx eeprom i2c master
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam int AddrBitsDef  = 16;
  localparam int CountBitsDef = 16;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_BYTE  = 2'd3;

  localparam logic [2:0] REG_DEVICE = 3'd0;
  localparam logic [2:0] REG_WIDE   = 3'd1;
  localparam logic [2:0] REG_RLIMIT = 3'd2;
  localparam logic [2:0] REG_RGAP   = 3'd3;
  localparam logic [2:0] REG_PAGE   = 3'd4;
  localparam logic [2:0] REG_DELAY  = 3'd5;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_START = 4'd1;
  localparam logic [3:0] PH_TXBIT = 4'd2;
  localparam logic [3:0] PH_TXACK = 4'd3;
  localparam logic [3:0] PH_GAP   = 4'd4;
  localparam logic [3:0] PH_WAIT  = 4'd5;
  localparam logic [3:0] PH_RXBIT = 4'd6;
  localparam logic [3:0] PH_RXACK = 4'd7;
  localparam logic [3:0] PH_STOP  = 4'd8;

  localparam logic [2:0] TG_CTRL  = 3'd0;
  localparam logic [2:0] TG_HI    = 3'd1;
  localparam logic [2:0] TG_LO    = 3'd2;
  localparam logic [2:0] TG_RCTRL = 3'd3;
  localparam logic [2:0] TG_DATA  = 3'd4;

  typedef struct packed {
    logic [6:0] device_code;
    logic       wide_address;
    logic [7:0] retry_limit;
    logic [7:0] retry_gap;
    logic [3:0] page_size_log2;
    logic [9:0] delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] mem_address;
    logic [15:0] byte_count;
    logic [7:0]  write_data;
    logic        sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic [7:0] read_data;
    logic       read_valid;
    logic       byte_request;
    logic       done_res;
    logic       failed;
  } res_t;

endpackage

// File: src/i2c_eeprom_master_top.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_master_top
// i2c master for 24cxx serial eeproms, one bus tick per input item
// ----------------------------------------------------------------------------
// Each input item is one tick; it yields exactly one result item carrying the
// scl and sda levels and the read, request and done flags. Items pass through
// a two-entry queue to the bus sequencer, which takes one item per clock
// cycle while its output register is free or being taken, so the sustained
// rate is one item per cycle; the queue and sequencer outputs are registered.
// Configuration must be written through the cfg channel while idle; unchecked.
module i2c_eeprom_master_top import i2cee_pkg::*; #(
  parameter int ADDRESS_BITS = AddrBitsDef,
  parameter int COUNT_BITS   = CountBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[1:0], mem_address[17:2], byte_count[33:18], write_data[41:34], sda_in[42]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_level[0], sda_release[1], read_data[9:2], read_valid[10],
  // byte_request[11], done_res[12], failed[13]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  cfg_t  cfg_r;
  tick_t q_in, q_out;
  logic  q_valid, q_ready;
  res_t  res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{device_code: 7'h50, wide_address: 1'b0, retry_limit: 8'd50,
                 retry_gap: 8'd20, page_size_log2: 4'd4, delay_ticks: 10'd1};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEVICE: cfg_r.device_code    <= cfg_data[6:0];
        REG_WIDE:   cfg_r.wide_address   <= cfg_data[0];
        REG_RLIMIT: cfg_r.retry_limit    <= cfg_data[7:0];
        REG_RGAP:   cfg_r.retry_gap      <= cfg_data[7:0];
        REG_PAGE:   cfg_r.page_size_log2 <= cfg_data[3:0];
        REG_DELAY:  cfg_r.delay_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign q_in = '{cmd: in_tdata[1:0], mem_address: in_tdata[17:2],
                  byte_count: in_tdata[33:18], write_data: in_tdata[41:34],
                  sda_in: in_tdata[42]};

  i2cee_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_data(q_in),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_out)
  );

  i2cee_engine #(.ADDRESS_BITS(ADDRESS_BITS), .COUNT_BITS(COUNT_BITS)) u_engine (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_out),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_item(res)
  );

  assign out_tdata = {2'b00, res.failed, res.done_res, res.byte_request, res.read_valid,
                      res.read_data, res.sda_release, res.scl_level};
endmodule

// File: src/i2cee_queue.sv
// ----------------------------------------------------------------------------
// i2cee_queue
// two-entry item queue between the front and the bus engine
// ----------------------------------------------------------------------------
module i2cee_queue import i2cee_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  tick_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output tick_t rd_data
);
  tick_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule

// File: src/i2cee_engine.sv
// ----------------------------------------------------------------------------
// i2cee_engine
// bus sequencer: one tick per item, result held in an output register
// ----------------------------------------------------------------------------
module i2cee_engine import i2cee_pkg::*; #(
  parameter int ADDRESS_BITS = AddrBitsDef,
  parameter int COUNT_BITS   = CountBitsDef
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  tick_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_item
);
  logic [3:0]              phase_r, phase_nxt;
  logic [1:0]              step_r, step_nxt;
  logic [2:0]              target_r, target_nxt;
  logic [9:0]              tick_r, tick_nxt;
  logic [3:0]              bit_r, bit_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [COUNT_BITS-1:0]   left_r, left_nxt;
  logic [7:0]              retry_r, retry_nxt, gap_r, gap_nxt;
  logic                    rd_r, rd_nxt, scl_r, scl_nxt, sda_r, sda_nxt;
  logic                    ov_r;
  res_t                    res_r, res_nxt;
  logic                    take;
  logic [15:0]             addr16;
  logic [7:0]              ctrl;
  logic [9:0]              dly;
  logic [ADDRESS_BITS-1:0] addr_inc;
  logic [15:0]             page_mask;

  assign in_ready  = !ov_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_item  = res_r;
  assign addr16    = 16'(addr_r);
  assign dly       = (cfg.delay_ticks == 10'd0) ? 10'd1 : cfg.delay_ticks;
  assign addr_inc  = addr_r + ADDRESS_BITS'(1);
  assign page_mask = 16'((17'd1 << cfg.page_size_log2) - 17'd1);

  always_comb begin
    ctrl = {cfg.device_code, 1'b0};
    if (!cfg.wide_address) ctrl = ctrl | ({5'd0, addr16[10:8]} << 1);
  end

  always_comb begin
    phase_nxt = phase_r; step_nxt = step_r; target_nxt = target_r; tick_nxt = tick_r;
    bit_nxt = bit_r; shift_nxt = shift_r; addr_nxt = addr_r; left_nxt = left_r;
    retry_nxt = retry_r; gap_nxt = gap_r; rd_nxt = rd_r; scl_nxt = scl_r; sda_nxt = sda_r;
    res_nxt = '0;
    // per-phase next state: bus levels, bytes to load and result flags
    unique case (phase_r)
      PH_IDLE: begin
        if (in_item.cmd == CMD_READ || in_item.cmd == CMD_WRITE) begin
          rd_nxt = (in_item.cmd == CMD_READ);
          addr_nxt = in_item.mem_address[ADDRESS_BITS-1:0];
          left_nxt = in_item.byte_count[COUNT_BITS-1:0];
          retry_nxt = '0; gap_nxt = '0; tick_nxt = '0;
          phase_nxt = PH_START; step_nxt = '0; target_nxt = TG_CTRL;
        end
      end
      PH_WAIT: begin
        if (in_item.cmd == CMD_BYTE) begin
          shift_nxt = in_item.write_data; tick_nxt = '0;
          phase_nxt = PH_TXBIT; step_nxt = '0; bit_nxt = '0; target_nxt = TG_DATA;
        end
      end
      default: begin
        tick_nxt = tick_r + 10'd1;
        if (tick_nxt >= dly) begin
          tick_nxt = '0;
          unique case (phase_r)
            PH_START: begin
              unique case (step_r)
                2'd0: scl_nxt = 1'b1;
                2'd1: sda_nxt = 1'b1;
                2'd2: sda_nxt = 1'b0;
                default: begin
                  scl_nxt = 1'b0; phase_nxt = PH_TXBIT; bit_nxt = '0;
                  priority case (target_r)
                    TG_CTRL:  shift_nxt = ctrl;
                    TG_RCTRL: shift_nxt = ctrl | 8'd1;
                    default: ;
                  endcase
                end
              endcase
              step_nxt = step_r + 2'd1;
            end
            PH_TXBIT: begin
              if (step_r == 2'd0) begin sda_nxt = shift_r[7]; step_nxt = 2'd1; end
              else if (step_r == 2'd1) begin scl_nxt = 1'b1; step_nxt = 2'd2; end
              else begin
                scl_nxt = 1'b0; shift_nxt = {shift_r[6:0], 1'b0};
                bit_nxt = bit_r + 4'd1; step_nxt = '0;
                if (bit_nxt >= 4'd8) phase_nxt = PH_TXACK;
              end
            end
            PH_TXACK: begin
              if (step_r == 2'd0) begin sda_nxt = 1'b1; step_nxt = 2'd1; end
              else if (step_r == 2'd1) begin scl_nxt = 1'b1; step_nxt = 2'd2; end
              else begin
                scl_nxt = 1'b0; sda_nxt = 1'b0; step_nxt = '0;
                if (!in_item.sda_in) begin
                  priority case (target_r)
                    TG_CTRL: begin
                      phase_nxt = PH_TXBIT; bit_nxt = '0;
                      target_nxt = cfg.wide_address ? TG_HI : TG_LO;
                      shift_nxt = cfg.wide_address ? addr16[15:8] : addr16[7:0];
                    end
                    TG_HI: begin
                      phase_nxt = PH_TXBIT; bit_nxt = '0; target_nxt = TG_LO;
                      shift_nxt = addr16[7:0];
                    end
                    TG_LO: begin
                      retry_nxt = '0;
                      if (rd_r) begin phase_nxt = PH_START; target_nxt = TG_RCTRL; end
                      else if (left_r == '0) phase_nxt = PH_STOP;
                      else phase_nxt = PH_WAIT;
                    end
                    TG_RCTRL: begin
                      if (left_r == '0) phase_nxt = PH_STOP;
                      else begin phase_nxt = PH_RXBIT; bit_nxt = '0; shift_nxt = '0; end
                    end
                    default: begin
                      left_nxt = left_r - COUNT_BITS'(1);
                      addr_nxt = addr_inc;
                      if ((16'(addr_inc) & page_mask) == 16'd0) begin
                        retry_nxt = '0; phase_nxt = PH_START; target_nxt = TG_CTRL;
                      end else if (left_nxt == '0) phase_nxt = PH_STOP;
                      else phase_nxt = PH_WAIT;
                    end
                  endcase
                end else if (target_r <= TG_LO) begin
                  if (retry_r != 8'd255) retry_nxt = retry_r + 8'd1;
                  gap_nxt = '0;
                  if (cfg.retry_gap != 8'd0) phase_nxt = PH_GAP;
                  else if (retry_nxt >= cfg.retry_limit) begin
                    res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1; phase_nxt = PH_IDLE;
                  end else begin phase_nxt = PH_START; target_nxt = TG_CTRL; end
                end else begin
                  res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1; phase_nxt = PH_IDLE;
                end
              end
            end
            PH_GAP: begin
              if (gap_r != 8'd255) gap_nxt = gap_r + 8'd1;
              if (gap_nxt >= cfg.retry_gap) begin
                step_nxt = '0;
                if (retry_r >= cfg.retry_limit) begin
                  res_nxt.done_res = 1'b1; res_nxt.failed = 1'b1; phase_nxt = PH_IDLE;
                end else begin phase_nxt = PH_START; target_nxt = TG_CTRL; end
              end
            end
            PH_RXBIT: begin
              if (step_r == 2'd0) begin sda_nxt = 1'b1; step_nxt = 2'd1; end
              else if (step_r == 2'd1) begin scl_nxt = 1'b1; step_nxt = 2'd2; end
              else begin
                scl_nxt = 1'b0; shift_nxt = {shift_r[6:0], in_item.sda_in};
                bit_nxt = bit_r + 4'd1; step_nxt = 2'd1;
                if (bit_nxt >= 4'd8) begin
                  res_nxt.read_valid = 1'b1; res_nxt.read_data = shift_nxt;
                  left_nxt = left_r - COUNT_BITS'(1); addr_nxt = addr_inc;
                  step_nxt = '0;
                  phase_nxt = (left_nxt != '0) ? PH_RXACK : PH_STOP;
                end
              end
            end
            PH_RXACK: begin
              unique case (step_r)
                2'd0: sda_nxt = 1'b0;
                2'd1: scl_nxt = 1'b1;
                2'd2: scl_nxt = 1'b0;
                default: begin
                  sda_nxt = 1'b1; phase_nxt = PH_RXBIT; bit_nxt = '0; shift_nxt = '0;
                end
              endcase
              step_nxt = step_r + 2'd1;
            end
            PH_STOP: begin
              if (step_r == 2'd0) begin sda_nxt = 1'b0; step_nxt = 2'd1; end
              else if (step_r == 2'd1) begin scl_nxt = 1'b1; step_nxt = 2'd2; end
              else begin
                sda_nxt = 1'b1; res_nxt.done_res = 1'b1; phase_nxt = PH_IDLE; step_nxt = '0;
              end
            end
            default: begin phase_nxt = PH_IDLE; step_nxt = '0; end
          endcase
        end
      end
    endcase
    res_nxt.scl_level    = scl_nxt;
    res_nxt.sda_release  = sda_nxt;
    res_nxt.byte_request = (phase_nxt == PH_WAIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; step_r <= '0; target_r <= TG_CTRL; tick_r <= '0;
      bit_r <= '0; shift_r <= '0; addr_r <= '0; left_r <= '0;
      retry_r <= '0; gap_r <= '0; rd_r <= 1'b0; scl_r <= 1'b1; sda_r <= 1'b1;
      ov_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt; step_r <= step_nxt; target_r <= target_nxt;
        tick_r <= tick_nxt; bit_r <= bit_nxt; shift_r <= shift_nxt;
        addr_r <= addr_nxt; left_r <= left_nxt; retry_r <= retry_nxt;
        gap_r <= gap_nxt; rd_r <= rd_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt;
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
    if (take) res_r <= res_nxt;
  end
endmodule

// File: src/i2cee_checker.sv
// ----------------------------------------------------------------------------
// i2cee_checker
// port-level checks for the eeprom master, bound to the top level
// ----------------------------------------------------------------------------
module i2cee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  a_fail_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[13] || out_tdata[12])) else $error("failed without done");
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[10]) |-> (out_tdata[9:2] == 8'd0)) else $error("stray data");
  a_no_req_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[12]) |-> !out_tdata[11]) else $error("request at done");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");
endmodule

bind i2c_eeprom_master_top i2cee_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
